// ----- hdl/mtta_pkg.sv -----
// Shared types, codes and sizing constants of the multi-topic timestamp aligner.
// No dependencies; every other file of the block imports this package.
package mtta_pkg;

   localparam int MAX_BOUNDARIES  = 8;
   localparam int MAX_ODO_PENDING = 16;
   localparam int SLOT_FRAMES     = 3;
   localparam int FRAME_SLOTS     = MAX_BOUNDARIES * SLOT_FRAMES;
   localparam int BIDX_W  = (MAX_BOUNDARIES > 1) ? $clog2(MAX_BOUNDARIES) : 1;
   localparam int OIDX_W  = (MAX_ODO_PENDING > 1) ? $clog2(MAX_ODO_PENDING) : 1;
   localparam int FADDR_W = $clog2(FRAME_SLOTS);

   localparam logic [1:0] REQ_OBSERVE = 2'd0;
   localparam logic [1:0] REQ_START   = 2'd1;
   localparam logic [1:0] REQ_STOP    = 2'd2;
   localparam logic [1:0] REQ_FORCE   = 2'd3;

   localparam logic [2:0] TOPIC_COMMAND      = 3'd0;
   localparam logic [2:0] TOPIC_ODOMETRY     = 3'd1;
   localparam logic [2:0] TOPIC_SENSOR_FIRST = 3'd2;
   localparam logic [2:0] TOPIC_COUNT        = 3'd5;

   localparam logic [2:0] MODE_IDLE       = 3'd0;
   localparam logic [2:0] MODE_WAIT_START = 3'd1;
   localparam logic [2:0] MODE_RECORDING  = 3'd2;
   localparam logic [2:0] MODE_WAIT_FINAL = 3'd3;
   localparam logic [2:0] MODE_READY      = 3'd4;
   localparam logic [2:0] MODE_SAFE       = 3'd5;

   localparam logic [3:0] FAIL_NONE       = 4'd0;
   localparam logic [3:0] FAIL_CMD_TIME   = 4'd1;
   localparam logic [3:0] FAIL_ODO_DUP    = 4'd2;
   localparam logic [3:0] FAIL_ODO_FULL   = 4'd3;
   localparam logic [3:0] FAIL_TOPIC      = 4'd4;
   localparam logic [3:0] FAIL_ZERO_TIME  = 4'd5;
   localparam logic [3:0] FAIL_TIME_SKEW  = 4'd6;
   localparam logic [3:0] FAIL_STALE      = 4'd7;
   localparam logic [3:0] FAIL_DUP_TOPIC  = 4'd8;
   localparam logic [3:0] FAIL_BOUND_FULL = 4'd9;
   localparam logic [3:0] FAIL_EXTERNAL   = 4'd10;

   localparam logic [3:0] MASK_USED     = 4'b0001;
   localparam logic [3:0] MASK_COMPLETE = 4'b1111;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [2:0]  topic;
      logic [63:0] log_time;
      logic [63:0] publish_time;
      logic [15:0] frame_tag;
   } req_item_type;

   typedef struct packed {
      logic        has_frame;
      logic [15:0] out_tag;
      logic [2:0]  out_topic;
      logic [63:0] out_time;
      logic        accepted;
      logic [2:0]  mode;
      logic [3:0]  fail_code;
      logic [31:0] late_drops;
      logic        last_item;
   } rsp_item_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_DECODE, OP_OSCAN, OP_OWRITE, OP_BSCAN, OP_BWRITE,
      OP_CSCAN, OP_CSET, OP_DISCARD, OP_CMIN, OP_CRD, OP_CEMIT, OP_OMIN,
      OP_OEMIT, OP_FINISH
   } dp_op_type;

   typedef enum logic [1:0] {
      CLS_DONE, CLS_ODO, CLS_SENSOR
   } dec_cls_type;

   typedef struct packed {
      dec_cls_type cls;
      logic        scan_end;
      logic        hit;
      logic        fault;
      logic        done;
      logic        k_last;
      logic        first;
   } dp_status_type;

endpackage

// ----- hdl/mtta_dp.sv -----
// Datapath of the aligner: mode and fault registers, boundary and odometry tables,
// scan logic, pending frame and result register. Depends on mtta_pkg.
module mtta_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  mtta_pkg::dp_op_type    cmd,
   input  mtta_pkg::req_item_type req_data,
   input  logic                   rsp_stall,
   output mtta_pkg::dp_status_type status,
   output logic                   rsp_valid,
   output mtta_pkg::rsp_item_type rsp_data
);
   import mtta_pkg::*;

   typedef struct packed {
      logic [15:0] tag;
      logic [2:0]  topic;
      logic [63:0] stamp;
   } frame_type;

   req_item_type item_ff, item_in;
   logic [2:0]   mode_ff, mode_in;
   logic [63:0]  lastb_ff, lastb_in;
   logic [31:0]  late_ff, late_in;
   logic [3:0]   fault_ff, fault_in;
   logic         acc_ff, acc_in;

   logic [63:0] bound_time_mem [MAX_BOUNDARIES];
   logic [3:0]  bmask_ff [MAX_BOUNDARIES];
   logic [3:0]  bmask_in [MAX_BOUNDARIES];
   logic [18:0] frames_mem [FRAME_SLOTS];
   logic [63:0] odo_time_mem [MAX_ODO_PENDING];
   logic [15:0] odo_tag_mem [MAX_ODO_PENDING];
   logic [MAX_ODO_PENDING-1:0] ovalid_ff, ovalid_in;

   logic [BIDX_W-1:0] bidx_ff, bidx_in, sel_b_ff, sel_b_in, free_b_ff, free_b_in;
   logic [OIDX_W-1:0] oidx_ff, oidx_in, sel_o_ff, sel_o_in, free_o_ff, free_o_in;
   logic              hit_ff, hit_in, free_found_ff, free_found_in, dup_ff, dup_in;
   logic [63:0]       sel_time_ff, sel_time_in, t_ff, t_in;
   logic [15:0]       sel_tag_ff, sel_tag_in;
   logic [1:0]        k_ff, k_in;
   logic [18:0]       rd_ff;
   logic              pend_valid_ff, pend_valid_in, out_valid_ff, out_valid_in;
   frame_type         pend_ff, pend_in, push_frame;
   rsp_item_type      out_ff, out_in;

   logic               bt_we, fr_we, od_we, rd_en;
   logic [BIDX_W-1:0]  bt_addr;
   logic [FADDR_W-1:0] fr_addr, rd_addr;
   logic [18:0]        fr_data;
   logic [OIDX_W-1:0]  od_addr;

   logic               fail_req;
   logic [3:0]         fail_cd;
   logic               push_req;
   dp_status_type      st;

   logic [63:0] cur_btime, cur_otime;
   logic [3:0]  cur_bmask, sel_mask, bitmask;
   logic [15:0] cur_otag;
   logic        cur_oval, b_first, o_first, b_last, o_last, out_free;
   logic        hit_b, hit_o, free_b_seen, free_o_seen, dup_seen;
   logic [1:0]  bitpos, sel_cnt;
   logic        lt_zero, lt_skew, lt_stale, mode_active;

   function automatic logic [1:0] frame_count(input logic [3:0] m);
      frame_count = 2'({1'b0, m[1]} + {1'b0, m[2]} + {1'b0, m[3]});
   endfunction

   function automatic rsp_item_type make_rsp(input frame_type f, input logic has,
                                              input logic last, input logic acc,
                                              input logic [2:0] md, input logic [3:0] fc,
                                              input logic [31:0] late);
      rsp_item_type r;
      r.has_frame  = has;
      r.out_tag    = has ? f.tag : 16'd0;
      r.out_topic  = has ? f.topic : 3'd0;
      r.out_time   = has ? f.stamp : 64'd0;
      r.accepted   = acc;
      r.mode       = md;
      r.fail_code  = fc;
      r.late_drops = late;
      r.last_item  = last;
      make_rsp = r;
   endfunction

   assign cur_btime   = bound_time_mem[bidx_ff];
   assign cur_bmask   = bmask_ff[bidx_ff];
   assign cur_otime   = odo_time_mem[oidx_ff];
   assign cur_otag    = odo_tag_mem[oidx_ff];
   assign cur_oval    = ovalid_ff[oidx_ff];
   assign sel_mask    = bmask_ff[sel_b_ff];
   assign sel_cnt     = frame_count(sel_mask);
   assign b_first     = (bidx_ff == '0);
   assign o_first     = (oidx_ff == '0);
   assign b_last      = (bidx_ff == BIDX_W'(MAX_BOUNDARIES - 1));
   assign o_last      = (oidx_ff == OIDX_W'(MAX_ODO_PENDING - 1));
   // scan flags restart at the first entry of every scan
   assign hit_b       = b_first ? 1'b0 : hit_ff;
   assign hit_o       = o_first ? 1'b0 : hit_ff;
   assign free_b_seen = b_first ? 1'b0 : free_found_ff;
   assign free_o_seen = o_first ? 1'b0 : free_found_ff;
   assign dup_seen    = o_first ? 1'b0 : dup_ff;
   assign bitpos      = 2'(item_ff.topic - 3'd1);
   assign bitmask     = 4'b0001 << bitpos;
   assign lt_zero     = (item_ff.log_time == 64'd0);
   assign lt_skew     = (item_ff.log_time != item_ff.publish_time);
   assign lt_stale    = (item_ff.log_time <= lastb_ff);
   assign mode_active = (mode_ff == MODE_WAIT_START) || (mode_ff == MODE_RECORDING) ||
                        (mode_ff == MODE_WAIT_FINAL);
   assign out_free    = !out_valid_ff || !rsp_stall;

   always_comb begin
      item_in       = item_ff;
      mode_in       = mode_ff;
      lastb_in      = lastb_ff;
      late_in       = late_ff;
      fault_in      = fault_ff;
      acc_in        = acc_ff;
      bmask_in      = bmask_ff;
      ovalid_in     = ovalid_ff;
      bidx_in       = bidx_ff;
      oidx_in       = oidx_ff;
      sel_b_in      = sel_b_ff;
      free_b_in     = free_b_ff;
      sel_o_in      = sel_o_ff;
      free_o_in     = free_o_ff;
      hit_in        = hit_ff;
      free_found_in = free_found_ff;
      dup_in        = dup_ff;
      sel_time_in   = sel_time_ff;
      t_in          = t_ff;
      sel_tag_in    = sel_tag_ff;
      k_in          = k_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = rsp_stall ? out_valid_ff : 1'b0;
      out_in        = out_ff;
      bt_we         = 1'b0;
      bt_addr       = free_b_ff;
      fr_we         = 1'b0;
      fr_addr       = FADDR_W'(FADDR_W'(free_b_ff) * FADDR_W'(SLOT_FRAMES));
      fr_data       = {item_ff.topic, item_ff.frame_tag};
      od_we         = 1'b0;
      od_addr       = free_o_ff;
      rd_en         = 1'b0;
      rd_addr       = FADDR_W'(FADDR_W'(sel_b_ff) * FADDR_W'(SLOT_FRAMES) + FADDR_W'(k_ff));
      fail_req      = 1'b0;
      fail_cd       = FAIL_NONE;
      push_req      = 1'b0;
      push_frame    = '0;
      st            = '0;
      st.cls        = CLS_DONE;

      case (cmd)
         OP_LOAD: begin
            item_in = req_data;
            acc_in  = 1'b0;
            bidx_in = '0;
            oidx_in = '0;
         end
         OP_DECODE: begin
            unique case (item_ff.req_type)
               REQ_START: begin
                  if (mode_ff == MODE_IDLE) begin
                     mode_in = MODE_WAIT_START;
                     acc_in  = 1'b1;
                  end
               end
               REQ_STOP: begin
                  if (mode_ff == MODE_RECORDING) begin
                     mode_in = MODE_WAIT_FINAL;
                     acc_in  = 1'b1;
                  end
               end
               REQ_FORCE: begin
                  fail_req = 1'b1;
                  fail_cd  = FAIL_EXTERNAL;
               end
               default: begin
                  if (mode_active) begin
                     if (item_ff.topic < TOPIC_SENSOR_FIRST) begin
                        if (lt_zero || lt_skew) begin
                           fail_req = 1'b1;
                           fail_cd  = FAIL_CMD_TIME;
                        end else if (mode_ff != MODE_WAIT_START) begin
                           if (item_ff.topic == TOPIC_COMMAND) begin
                              pend_valid_in = 1'b1;
                              pend_in       = '{tag: item_ff.frame_tag,
                                                topic: TOPIC_COMMAND,
                                                stamp: item_ff.log_time};
                           end else if (lt_stale) begin
                              if (late_ff != '1) late_in = late_ff + 32'd1;
                           end else begin
                              st.cls = CLS_ODO;
                           end
                        end
                     end else if (item_ff.topic >= TOPIC_COUNT) begin
                        fail_req = 1'b1;
                        fail_cd  = FAIL_TOPIC;
                     end else if (lt_zero) begin
                        fail_req = 1'b1;
                        fail_cd  = FAIL_ZERO_TIME;
                     end else if (lt_skew) begin
                        fail_req = 1'b1;
                        fail_cd  = FAIL_TIME_SKEW;
                     end else if (lt_stale) begin
                        fail_req = 1'b1;
                        fail_cd  = FAIL_STALE;
                     end else begin
                        st.cls = CLS_SENSOR;
                     end
                  end
               end
            endcase
         end
         OP_OSCAN: begin
            dup_in        = dup_seen;
            free_found_in = free_o_seen;
            if (cur_oval) begin
               if (cur_otime == item_ff.log_time) dup_in = 1'b1;
            end else if (!free_o_seen) begin
               free_found_in = 1'b1;
               free_o_in     = oidx_ff;
            end
            st.scan_end = o_last;
            oidx_in     = o_last ? '0 : oidx_ff + 1'b1;
         end
         OP_OWRITE: begin
            if (dup_ff) begin
               fail_req = 1'b1;
               fail_cd  = FAIL_ODO_DUP;
            end else if (!free_found_ff) begin
               fail_req = 1'b1;
               fail_cd  = FAIL_ODO_FULL;
            end else begin
               od_we                = 1'b1;
               ovalid_in[free_o_ff] = 1'b1;
            end
         end
         OP_BSCAN: begin
            hit_in        = hit_b;
            free_found_in = free_b_seen;
            if (cur_bmask[0]) begin
               if (cur_btime == item_ff.log_time) begin
                  hit_in   = 1'b1;
                  sel_b_in = bidx_ff;
               end
            end else if (!free_b_seen) begin
               free_found_in = 1'b1;
               free_b_in     = bidx_ff;
            end
            st.scan_end = b_last;
            bidx_in     = b_last ? '0 : bidx_ff + 1'b1;
         end
         OP_BWRITE: begin
            if (hit_ff) begin
               if ((sel_mask & bitmask) != 4'd0) begin
                  fail_req = 1'b1;
                  fail_cd  = FAIL_DUP_TOPIC;
               end else begin
                  fr_we              = 1'b1;
                  fr_addr            = FADDR_W'(FADDR_W'(sel_b_ff) * FADDR_W'(SLOT_FRAMES)
                                       + FADDR_W'(sel_cnt));
                  bmask_in[sel_b_ff] = sel_mask | bitmask;
               end
            end else if (!free_found_ff) begin
               fail_req = 1'b1;
               fail_cd  = FAIL_BOUND_FULL;
            end else begin
               bt_we               = 1'b1;
               fr_we               = 1'b1;
               bmask_in[free_b_ff] = MASK_USED | bitmask;
            end
            st.fault = fail_req;
         end
         OP_CSCAN: begin
            // oldest boundary that holds all three sensors
            hit_in = hit_b;
            if (cur_bmask == MASK_COMPLETE && (!hit_b || cur_btime < sel_time_ff)) begin
               hit_in      = 1'b1;
               sel_b_in    = bidx_ff;
               sel_time_in = cur_btime;
            end
            st.scan_end = b_last;
            st.hit      = hit_in;
            bidx_in     = b_last ? '0 : bidx_ff + 1'b1;
         end
         OP_CSET: begin
            t_in     = sel_time_ff;
            st.first = (lastb_ff == 64'd0);
            if (mode_ff == MODE_WAIT_START) mode_in = MODE_RECORDING;
            else if (mode_ff == MODE_WAIT_FINAL) mode_in = MODE_READY;
         end
         OP_DISCARD: begin
            if (cur_bmask[0] && cur_btime < t_ff) bmask_in[bidx_ff] = 4'd0;
            st.scan_end = b_last;
            bidx_in     = b_last ? '0 : bidx_ff + 1'b1;
         end
         OP_CMIN: begin
            hit_in = hit_b;
            if (cur_bmask[0] && cur_btime <= t_ff && (!hit_b || cur_btime < sel_time_ff)) begin
               hit_in      = 1'b1;
               sel_b_in    = bidx_ff;
               sel_time_in = cur_btime;
            end
            k_in        = 2'd0;
            st.scan_end = b_last;
            st.hit      = hit_in;
            bidx_in     = b_last ? '0 : bidx_ff + 1'b1;
         end
         OP_CRD: begin
            rd_en = 1'b1;
         end
         OP_CEMIT: begin
            push_req   = 1'b1;
            push_frame = '{tag: rd_ff[15:0], topic: rd_ff[18:16], stamp: sel_time_ff};
         end
         OP_OMIN: begin
            hit_in = hit_o;
            if (cur_oval && cur_otime <= t_ff && (!hit_o || cur_otime < sel_time_ff)) begin
               hit_in      = 1'b1;
               sel_o_in    = oidx_ff;
               sel_time_in = cur_otime;
               sel_tag_in  = cur_otag;
            end
            if (o_last && !hit_in) lastb_in = t_ff;
            st.scan_end = o_last;
            st.hit      = hit_in;
            oidx_in     = o_last ? '0 : oidx_ff + 1'b1;
         end
         OP_OEMIT: begin
            push_req   = 1'b1;
            push_frame = '{tag: sel_tag_ff, topic: TOPIC_ODOMETRY, stamp: sel_time_ff};
         end
         OP_FINISH: begin
            if (out_free) begin
               out_in        = make_rsp(pend_ff, pend_valid_ff, 1'b1, acc_ff, mode_ff,
                                        fault_ff, late_ff);
               out_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               st.done       = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // hold one frame back so the final one can carry the last-item mark
      if (push_req) begin
         if (!pend_valid_ff) begin
            pend_valid_in = 1'b1;
            pend_in       = push_frame;
            st.done       = 1'b1;
         end else if (out_free) begin
            out_in       = make_rsp(pend_ff, 1'b1, 1'b0, acc_ff, mode_ff, fault_ff, late_ff);
            out_valid_in = 1'b1;
            pend_in      = push_frame;
            st.done      = 1'b1;
         end
      end

      if (cmd == OP_CEMIT && st.done) begin
         k_in = k_ff + 2'd1;
         if (k_ff == sel_cnt - 2'd1) begin
            st.k_last          = 1'b1;
            bmask_in[sel_b_ff] = 4'd0;
         end
      end
      if (cmd == OP_OEMIT && st.done) ovalid_in[sel_o_ff] = 1'b0;

      if (fail_req) begin
         for (int i = 0; i < MAX_BOUNDARIES; i++) bmask_in[i] = 4'd0;
         ovalid_in = '0;
         fault_in  = fail_cd;
         mode_in   = MODE_SAFE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         lastb_ff      <= 64'd0;
         late_ff       <= 32'd0;
         fault_ff      <= FAIL_NONE;
         acc_ff        <= 1'b0;
         ovalid_ff     <= '0;
         bidx_ff       <= '0;
         oidx_ff       <= '0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         dup_ff        <= 1'b0;
         k_ff          <= 2'd0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         for (int i = 0; i < MAX_BOUNDARIES; i++) bmask_ff[i] <= 4'd0;
      end else begin
         mode_ff       <= mode_in;
         lastb_ff      <= lastb_in;
         late_ff       <= late_in;
         fault_ff      <= fault_in;
         acc_ff        <= acc_in;
         ovalid_ff     <= ovalid_in;
         bidx_ff       <= bidx_in;
         oidx_ff       <= oidx_in;
         hit_ff        <= hit_in;
         free_found_ff <= free_found_in;
         dup_ff        <= dup_in;
         k_ff          <= k_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         for (int i = 0; i < MAX_BOUNDARIES; i++) bmask_ff[i] <= bmask_in[i];
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      sel_b_ff    <= sel_b_in;
      free_b_ff   <= free_b_in;
      sel_o_ff    <= sel_o_in;
      free_o_ff   <= free_o_in;
      sel_time_ff <= sel_time_in;
      t_ff        <= t_in;
      sel_tag_ff  <= sel_tag_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
   end

   always_ff @(posedge clock) begin
      if (bt_we) bound_time_mem[bt_addr] <= item_ff.log_time;
      if (fr_we) frames_mem[fr_addr] <= fr_data;
      if (od_we) begin
         odo_time_mem[od_addr] <= item_ff.log_time;
         odo_tag_mem[od_addr]  <= item_ff.frame_tag;
      end
      if (rd_en) rd_ff <= frames_mem[rd_addr];
   end

   assign status    = st;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ----- hdl/mtta_ctrl.sv -----
// Sequencer of the aligner: walks each request through decode, table scans,
// commit and result delivery by issuing datapath operations. Depends on mtta_pkg.
module mtta_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  mtta_pkg::dp_status_type status,
   output logic                    req_stall,
   output mtta_pkg::dp_op_type     cmd
);
   import mtta_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_OSCAN, S_OWRITE, S_BSCAN, S_BWRITE, S_CSCAN, S_CSET,
      S_DISCARD, S_CMIN, S_CRD, S_CEMIT, S_OMIN, S_OEMIT, S_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd      = OP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd = OP_DECODE;
            unique case (status.cls)
               CLS_ODO:    state_in = S_OSCAN;
               CLS_SENSOR: state_in = S_BSCAN;
               default:    state_in = S_FINISH;
            endcase
         end
         S_OSCAN: begin
            cmd = OP_OSCAN;
            if (status.scan_end) state_in = S_OWRITE;
         end
         S_OWRITE: begin
            cmd      = OP_OWRITE;
            state_in = S_FINISH;
         end
         S_BSCAN: begin
            cmd = OP_BSCAN;
            if (status.scan_end) state_in = S_BWRITE;
         end
         S_BWRITE: begin
            cmd      = OP_BWRITE;
            state_in = status.fault ? S_FINISH : S_CSCAN;
         end
         S_CSCAN: begin
            cmd = OP_CSCAN;
            if (status.scan_end) state_in = status.hit ? S_CSET : S_FINISH;
         end
         S_CSET: begin
            cmd      = OP_CSET;
            state_in = status.first ? S_DISCARD : S_CMIN;
         end
         S_DISCARD: begin
            cmd = OP_DISCARD;
            if (status.scan_end) state_in = S_CMIN;
         end
         S_CMIN: begin
            cmd = OP_CMIN;
            if (status.scan_end) state_in = status.hit ? S_CRD : S_OMIN;
         end
         S_CRD: begin
            cmd      = OP_CRD;
            state_in = S_CEMIT;
         end
         S_CEMIT: begin
            cmd = OP_CEMIT;
            if (status.done) state_in = status.k_last ? S_CMIN : S_CRD;
         end
         S_OMIN: begin
            cmd = OP_OMIN;
            if (status.scan_end) state_in = status.hit ? S_OEMIT : S_FINISH;
         end
         S_OEMIT: begin
            cmd = OP_OEMIT;
            if (status.done) state_in = S_OMIN;
         end
         S_FINISH: begin
            cmd = OP_FINISH;
            if (status.done) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ----- hdl/multi_topic_timestamp_aligner_top.sv -----
// Top level of the multi-topic timestamp aligner: sequencer plus datapath.
// Depends on mtta_pkg, mtta_ctrl and mtta_dp.
//
// Recording window that lines up frames of five topics by log timestamp. Each
// request (observe, start, stop, force safe stop) gives one or more results on
// the rsp channel; the final result of a request carries last_item, and a
// request that emits no frame still gives one status-only result. Sensor
// topics 2..4 gather in an 8-entry boundary table; the oldest boundary with all
// three sensors commits itself and every older boundary (on the very first
// commit older ones are discarded instead), then every buffered odometry frame
// at or before it, in timestamp order. Any fault clears both tables, latches
// fail_code and parks the block in safe stop until reset.
// Requests are taken one at a time. Start, stop, force, ignored, dropped and late
// frames and decode faults pass through load, decode and finish. A buffered
// odometry frame adds one pass over the 16-entry odometry table, then the
// write. A sensor frame adds one pass over the boundary table to place it and,
// unless placing it faults, one pass to look for a complete boundary. A commit
// adds the set step, a discard pass on the very first commit, one pass over the
// boundary table per committed boundary plus a closing pass, a read and an emit
// step per sensor frame, one pass over the odometry table per committed
// odometry frame plus a closing pass, and an emit step per odometry frame. Every
// table entry is visited in its own cycle. A stalled result channel holds the
// finish step, and each emitted frame that must push out the held-back one,
// until the output register is free. Results sit in an output register, so a
// new request is taken while the last result of the previous one still waits.
module multi_topic_timestamp_aligner_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mtta_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mtta_pkg::rsp_item_type rsp_data
);
   import mtta_pkg::*;

   dp_op_type     cmd;
   dp_status_type status;

   // sequencer: hold requests off while one is in flight
   mtta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   // datapath: tables, scans and result register
   mtta_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // a latched fault and safe stop always go together
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.fail_code != FAIL_NONE) == (rsp_data.mode == MODE_SAFE)))
      else $error("fail code and safe stop disagree");

   // a status-only result always closes its request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_frame |-> rsp_data.last_item)
      else $error("status-only result not marked last");

   // accepted start or stop never comes with a frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.accepted |-> !rsp_data.has_frame)
      else $error("frame emitted on an accepted start or stop");

   // emitted frames name a real topic
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.has_frame |-> rsp_data.out_topic < TOPIC_COUNT)
      else $error("frame with out-of-range topic");

endmodule
